>>> hdl/jadc_pkg.sv
// Shared constants, stage records and helpers for the joystick drive command block.
`default_nettype none

package jadc_pkg;

    // Controller kinds held in the mode register
    localparam logic [1:0] MODE_STICK   = 2'd0;
    localparam logic [1:0] MODE_GAMEPAD = 2'd1;
    localparam logic [1:0] MODE_RUDDER  = 2'd2;

    // Axis numbers that carry meaning in each mode
    localparam logic [7:0] AXIS_STEER        = 8'd0;
    localparam logic [7:0] AXIS_STICK_DRIVE  = 8'd4;
    localparam logic [7:0] AXIS_PAD_STEER    = 8'd3;
    localparam logic [7:0] AXIS_PAD_FWD      = 8'd2;
    localparam logic [7:0] AXIS_PAD_REV      = 8'd5;
    localparam logic [7:0] AXIS_RUDDER_FWD   = 8'd3;
    localparam logic [7:0] AXIS_RUDDER_REV   = 8'd2;

    // Trigger split and rudder scaling
    localparam logic signed [16:0] HALF_OFFSET   = 17'sd16384;
    localparam logic signed [16:0] FULL_SCALE    = 17'sd32768;
    localparam logic signed [15:0] RUDDER_LIMIT  = 16'sd7000;
    localparam logic signed [31:0] RUDDER_BIAS   = 32'sd458738000;
    // floor(a / 14000) = ((a >> 4) * RECIP_M) >> RECIP_SHIFT for a below 2^29
    localparam logic [25:0]        RECIP_M       = 26'd39268273;
    localparam int                 RECIP_SHIFT   = 35;

    // Command mapping
    localparam logic signed [17:0] STEER_CENTER  = 18'sd32768;
    localparam logic [6:0]         STEER_MAX     = 7'd120;
    localparam logic [6:0]         STEER_RESET   = 7'd85;
    localparam logic [6:0]         STEER_STEP    = 7'd5;
    localparam logic [7:0]         THROTTLE_STEP = 8'd10;
    localparam logic [7:0]         DIV5_M        = 8'd205;

    // Routing decision for one item, after the first stage
    typedef struct packed {
        logic                upd_steer;
        logic                upd_drive;
        logic                rudder;
        logic                rud_neg;
        logic [24:0]         rud_mag;
        logic signed [16:0]  steer_val;
        logic signed [16:0]  drive_val;
    } route_t;

    // New axis values for one item, after rudder scaling
    typedef struct packed {
        logic                upd_steer;
        logic                upd_drive;
        logic signed [16:0]  steer_val;
        logic signed [16:0]  drive_val;
    } axes_t;

    // Exact floor(p / 5) for any 7-bit p
    function automatic logic [4:0] div5(input logic [6:0] p);
        logic [14:0] prod;
        prod = {8'd0, p} * {7'd0, DIV5_M};
        return prod[14:10];
    endfunction

endpackage

`default_nettype wire

>>> hdl/jadc_axis_if.sv
// Channel carrying joystick axis events.
`default_nettype none

interface jadc_axis_if;
    logic               valid;
    logic               ready;
    logic [7:0]         axis_number;
    logic signed [15:0] axis_value;

    modport source (output valid, output axis_number, output axis_value, input ready);
    modport sink   (input valid, input axis_number, input axis_value, output ready);
endinterface

`default_nettype wire

>>> hdl/jadc_cmd_if.sv
// Channel carrying drive commands.
`default_nettype none

interface jadc_cmd_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] throttle_cmd;
    logic [6:0]        steering_cmd;

    modport source (output valid, output throttle_cmd, output steering_cmd, input ready);
    modport sink   (input valid, input throttle_cmd, input steering_cmd, output ready);
endinterface

`default_nettype wire

>>> hdl/joystick_axis_to_drive_command_top.sv
// Joystick axis events in, steering and throttle commands out.
//
// Usage:
//   axis_in  : valid/ready channel of axis events (axis_number, axis_value).
//   cmd_out  : valid/ready channel of commands (throttle_cmd, steering_cmd).
//   cfg_we / cfg_wdata : write the controller mode (stick, gamepad, rudder).
//     Write the mode only while no event is in flight.
// Each event routes to the stored steering or drive axis according to the mode;
// both axes are then mapped to commands, and an item leaves on cmd_out only when
// a command differs from the last one sent. The first event always sends.
// An accepted event passes the input register, routing stage, rudder scaling stage,
// then compare into the output register before it reaches cmd_out.
// Throughput: one event per cycle unless cmd_out stalls; the rudder divide by 14000
// is a reciprocal multiply in its own stage, so no stage iterates.
// Reset clears all stage valids, sets mode to stick and forgets the last command.
// When cmd_out stalls, the last stage holds and the earlier stages keep filling
// their empty slots; axis_in drops ready only once every stage holds an item.
`default_nettype none

module joystick_axis_to_drive_command_top
    import jadc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,
    jadc_axis_if.sink        axis_in,
    jadc_cmd_if.source       cmd_out
);

    // Mode register
    logic [1:0] mode_reg;

    // Stage 0: input register
    logic               s0_valid_reg;
    logic [7:0]         s0_axis_reg;
    logic signed [15:0] s0_value_reg;

    // Stage 1: routing decision
    logic   s1_valid_reg;
    route_t s1_reg;
    route_t s1_next;

    // Stage 2: new axis values
    logic   s2_valid_reg;
    axes_t  s2_reg;
    axes_t  s2_next;

    // Output stage: last sent command doubles as the output payload
    logic              out_valid_reg;
    logic              sent_once_reg;
    logic [6:0]        last_steer_reg;
    logic signed [8:0] last_thr_reg;

    // Handshake chain
    logic out_free;
    logic s2_ready;
    logic s1_ready;
    logic s0_ready;
    logic fire2;

    assign out_free = !out_valid_reg || cmd_out.ready;
    assign s2_ready = !s2_valid_reg || out_free;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign fire2    = s2_valid_reg && out_free;

    assign axis_in.ready = s0_ready;

    // ---------------------------------------------------------------
    // Stage 1 logic: routing decision, trigger split, rudder clamp and numerator
    // ---------------------------------------------------------------
    logic signed [16:0] v_ext;
    logic signed [16:0] v_sum;
    logic signed [16:0] v_half;
    logic signed [16:0] trig;
    logic signed [15:0] clamped;
    logic signed [15:0] d_sum;
    logic [14:0]        d_val;
    logic [30:0]        rud_prod;
    logic signed [31:0] rud_num;
    logic [31:0]        rud_abs;

    assign v_ext  = {s0_value_reg[15], s0_value_reg};
    // Truncate toward zero: bump negative values by one before the shift
    assign v_sum  = v_ext + $signed({16'd0, s0_value_reg[15]});
    assign v_half = v_sum >>> 1;
    assign trig   = v_half + HALF_OFFSET;

    always_comb
    begin
        if (s0_value_reg > RUDDER_LIMIT)
        begin
            clamped = RUDDER_LIMIT;
        end
        else if (s0_value_reg < -RUDDER_LIMIT)
        begin
            clamped = -RUDDER_LIMIT;
        end
        else
        begin
            clamped = s0_value_reg;
        end
    end

    assign d_sum    = clamped + RUDDER_LIMIT;
    assign d_val    = d_sum[14:0];
    // d * 65535 as a shift and subtract
    assign rud_prod = {d_val, 16'd0} - {16'd0, d_val};
    assign rud_num  = $signed({1'b0, rud_prod}) - RUDDER_BIAS;
    assign rud_abs  = rud_num[31] ? 32'(-rud_num) : 32'(rud_num);

    always_comb
    begin
        s1_next           = '0;
        s1_next.rud_neg   = rud_num[31];
        s1_next.rud_mag   = rud_abs[28:4];
        s1_next.steer_val = v_ext;
        case (mode_reg)
            MODE_STICK:
            begin
                if (s0_axis_reg == AXIS_STEER)
                begin
                    s1_next.upd_steer = 1'b1;
                end
                else if (s0_axis_reg == AXIS_STICK_DRIVE)
                begin
                    s1_next.upd_drive = 1'b1;
                    s1_next.drive_val = v_ext;
                end
            end
            MODE_GAMEPAD:
            begin
                if (s0_axis_reg == AXIS_STEER || s0_axis_reg == AXIS_PAD_STEER)
                begin
                    s1_next.upd_steer = 1'b1;
                end
                else if (s0_axis_reg == AXIS_PAD_FWD)
                begin
                    s1_next.upd_drive = 1'b1;
                    s1_next.drive_val = trig;
                end
                else if (s0_axis_reg == AXIS_PAD_REV)
                begin
                    s1_next.upd_drive = 1'b1;
                    s1_next.drive_val = -trig;
                end
            end
            MODE_RUDDER:
            begin
                if (s0_axis_reg == AXIS_STEER)
                begin
                    s1_next.upd_steer = 1'b1;
                    s1_next.rudder    = 1'b1;
                end
                else if (s0_axis_reg == AXIS_RUDDER_FWD)
                begin
                    s1_next.upd_drive = 1'b1;
                    s1_next.drive_val = FULL_SCALE - trig;
                end
                else if (s0_axis_reg == AXIS_RUDDER_REV)
                begin
                    s1_next.upd_drive = 1'b1;
                    s1_next.drive_val = trig - FULL_SCALE;
                end
            end
            default:
            begin
                // Undefined mode routes nothing
                s1_next.upd_steer = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Stage 2 logic: rudder divide by 14000 as a reciprocal multiply
    // ---------------------------------------------------------------
    logic [50:0]        recip_prod;
    logic [15:0]        rud_q;
    logic signed [16:0] rud_steer;

    assign recip_prod = {26'd0, s1_reg.rud_mag} * {25'd0, RECIP_M};
    assign rud_q      = recip_prod[RECIP_SHIFT +: 16];
    assign rud_steer  = s1_reg.rud_neg ? -$signed({1'b0, rud_q}) : $signed({1'b0, rud_q});

    always_comb
    begin
        s2_next.upd_steer = s1_reg.upd_steer;
        s2_next.upd_drive = s1_reg.upd_drive;
        s2_next.steer_val = s1_reg.rudder ? rud_steer : s1_reg.steer_val;
        s2_next.drive_val = s1_reg.drive_val;
    end

    // ---------------------------------------------------------------
    // Output stage logic: map axes to commands, compare with last sent
    // ---------------------------------------------------------------
    logic signed [17:0] steer_shift;
    logic [16:0]        steer_pos;
    logic [22:0]        steer_scaled;
    logic [6:0]         steer_raw;
    logic [6:0]         steer_map;
    logic [16:0]        drive_abs;
    logic [24:0]        drive_scaled;
    logic [4:0]         thr_q;
    logic [7:0]         thr_mag;
    logic signed [8:0]  thr_map;
    logic [6:0]         steer_next;
    logic signed [8:0]  thr_next;
    logic               emit;

    assign steer_shift  = {s2_reg.steer_val[16], s2_reg.steer_val} + STEER_CENTER;
    assign steer_pos    = steer_shift[16:0];
    // (pos * 65) >> 16, the sign of the scale folded into the subtract below
    assign steer_scaled = {steer_pos, 6'd0} + {6'd0, steer_pos};
    assign steer_raw    = STEER_MAX - steer_scaled[22:16];
    assign steer_map    = {2'd0, div5(steer_raw)} * STEER_STEP;

    assign drive_abs    = s2_reg.drive_val[16] ? 17'(-s2_reg.drive_val)
                                               : 17'(s2_reg.drive_val);
    assign drive_scaled = {drive_abs, 8'd0} - {8'd0, drive_abs};
    // |drive| * 255 / 327680 = ((|drive| * 255) >> 16) / 5
    assign thr_q        = div5(drive_scaled[22:16]);
    assign thr_mag      = {3'd0, thr_q} * THROTTLE_STEP;
    assign thr_map      = s2_reg.drive_val[16] ? $signed({1'b0, thr_mag})
                                               : -$signed({1'b0, thr_mag});

    assign steer_next = s2_reg.upd_steer ? steer_map : last_steer_reg;
    assign thr_next   = s2_reg.upd_drive ? thr_map : last_thr_reg;
    assign emit       = !sent_once_reg || steer_next != last_steer_reg
                        || thr_next != last_thr_reg;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_STICK;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_ready)
            begin
                s0_valid_reg <= axis_in.valid;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Stage payloads advance with their valids
    always_ff @(posedge clk)
    begin
        if (s0_ready)
        begin
            s0_axis_reg  <= axis_in.axis_number;
            s0_value_reg <= axis_in.axis_value;
        end
        if (s1_ready)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready)
        begin
            s2_reg <= s2_next;
        end
    end

    // Last sent command is state: the first event after reset always sends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            sent_once_reg  <= 1'b0;
            last_steer_reg <= STEER_RESET;
            last_thr_reg   <= '0;
        end
        else if (fire2)
        begin
            out_valid_reg <= emit;
            if (emit)
            begin
                sent_once_reg  <= 1'b1;
                last_steer_reg <= steer_next;
                last_thr_reg   <= thr_next;
            end
        end
        else if (cmd_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign cmd_out.valid        = out_valid_reg;
    assign cmd_out.throttle_cmd = last_thr_reg;
    assign cmd_out.steering_cmd = last_steer_reg;

`ifndef SYNTHESIS
    // A command only goes out after something has been sent
    a_valid_after_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> sent_once_reg)
        else $error("command valid before any item was sent");

    // The last stage never overwrites a command still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !cmd_out.ready) |=>
            ($stable(last_steer_reg) && $stable(last_thr_reg)))
        else $error("pending command changed while stalled");

    // Steering stays within the servo range
    a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
        (last_steer_reg >= 7'd55 && last_steer_reg <= STEER_MAX))
        else $error("steering command out of range");

    // Throttle stays within its range
    a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (last_thr_reg >= -9'sd250 && last_thr_reg <= 9'sd250))
        else $error("throttle command out of range");
`endif

endmodule

`default_nettype wire
